[sv/assert_macros.svh]
// Assertion macros for the RTL of the logistic regression step unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked property, switched off while reset is asserted.
`define LRS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Checked property that also holds during reset.
`define LRS_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LRS_ASSERT(name, clk, rst_n, prop, msg)
`define LRS_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

[sv/lrs_pkg.sv]
// Shared types, widths, constants and functions of the logistic regression step unit.
package lrs_pkg;

    localparam int FEATURES        = 9;
    localparam int SIGMOID_ENTRIES = 256;

    localparam int X_W      = 16;   // feature, signed Q8.8
    localparam int W_W      = 32;   // weight and bias, signed Q16.16
    localparam int P_W      = 16;   // probability, unsigned Q0.16
    localparam int LR_W     = 16;   // learning rate, unsigned Q0.16
    localparam int LRE_W    = 34;   // lr * (p - label), signed Q0.32
    localparam int PROD_W   = 50;   // lane product, wide enough for both uses
    localparam int ACC_W    = 52;   // dot product accumulator, Q24.24
    localparam int SAT_IN_W = 44;   // input width of the Q16.16 saturation
    localparam int ZC_W     = 20;   // clamped logit, covers [-8, 8)

    localparam logic [LR_W-1:0] LR_RESET = 16'd655;

    typedef struct packed {
        logic load_x;   // capture the sample's feature
        logic mul_en;   // register the lane product
        logic mul_upd;  // product of the update term instead of the weight
        logic apply;    // write the updated weight
    } t_lane_ctrl;

    typedef struct packed {
        logic busy;     // accumulation in progress
        logic last;     // logit is written at this edge
    } t_merge_stat;

    // Saturate a signed value to the signed 32-bit range.
    function automatic logic signed [W_W-1:0] sat_q16(input logic signed [SAT_IN_W-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[SAT_IN_W-1:W_W-1];
        all_zero = ~|v[SAT_IN_W-1:W_W-1];
        if (all_one || all_zero) begin
            return v[W_W-1:0];
        end else if (v[SAT_IN_W-1]) begin
            return {1'b1, {(W_W-1){1'b0}}};
        end else begin
            return {1'b0, {(W_W-1){1'b1}}};
        end
    endfunction

    // Sigmoid table entry for a bin whose midpoint is m (Q16.16).
    // Only evaluated at elaboration to build the constant table.
    function automatic logic [P_W-1:0] sigmoid_at(input longint m);
        logic [63:0] a;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] t3;
        logic [63:0] t4;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] rem;
        int i;
        a  = (m < 0) ? 64'(-m) : 64'(m);
        t  = a << 7;
        t2 = (t * t) >> 31;
        t3 = (t2 * t) >> 31;
        t4 = (t3 * t) >> 31;
        // Taylor series of exp(-a/256), then squared eight times.
        e  = ((64'd1 << 31) + t2 / 64'd2 + t4 / 64'd24) - (t + t3 / 64'd6);
        for (i = 0; i < 8; i++) begin
            e = (e * e + (64'd1 << 30)) >> 31;
        end
        d = (64'd1 << 31) + e;
        if (m >= 0) begin
            num = (64'd1 << 47) + (d >> 1);
        end else begin
            num = (e << 16) + (d >> 1);
        end
        // Restoring long division, one quotient bit per step.
        q   = 64'd0;
        rem = 64'd0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            q   = q << 1;
            if (rem >= d) begin
                rem  = rem - d;
                q[0] = 1'b1;
            end
        end
        return (q > 64'd65535) ? {P_W{1'b1}} : q[P_W-1:0];
    endfunction

endpackage

[sv/lrs_lane.sv]
// One feature lane: holds a weight, multiplies for the dot product and applies the SGD step.
module lrs_lane (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lrs_pkg::t_lane_ctrl                   i_ctrl,
    input  logic signed [lrs_pkg::X_W-1:0]        i_x,
    input  logic signed [lrs_pkg::LRE_W-1:0]      i_lre,
    output logic signed [lrs_pkg::PROD_W-1:0]     o_prod
);

    localparam int PROD_W = lrs_pkg::PROD_W;

    logic signed [lrs_pkg::W_W-1:0]      r_w;
    logic signed [lrs_pkg::X_W-1:0]      r_x;
    logic signed [PROD_W-1:0]            r_prod;
    logic signed [lrs_pkg::LRE_W-1:0]    w_a;
    logic signed [PROD_W-1:0]            w_mul;
    logic signed [PROD_W:0]              w_rnd;
    logic signed [PROD_W-24:0]           w_step;
    logic signed [lrs_pkg::SAT_IN_W-1:0] w_diff;

    // The multiplier is shared: weight times feature for the logit,
    // lr*(p-label) times feature for the update.
    assign w_a   = i_ctrl.mul_upd ? i_lre : lrs_pkg::LRE_W'(r_w);
    assign w_mul = w_a * r_x;

    // Round to nearest, ties up, from Q8.40 to Q16.16.
    assign w_rnd  = {r_prod[PROD_W-1], r_prod} + {{(PROD_W-23){1'b0}}, 1'b1, 23'd0};
    assign w_step = w_rnd[PROD_W:24];
    assign w_diff = lrs_pkg::SAT_IN_W'(r_w) - lrs_pkg::SAT_IN_W'(w_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= '0;
        end else if (i_ctrl.apply) begin
            r_w <= lrs_pkg::sat_q16(w_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_x) begin
            r_x <= i_x;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= w_mul;
        end
    end

    assign o_prod = r_prod;

endmodule

[sv/lrs_merge.sv]
// Merging stage: sums the lane products and the bias two terms a cycle, then saturates the logit.
module lrs_merge #(
    parameter int NTERMS = lrs_pkg::FEATURES + 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic signed [lrs_pkg::ACC_W-1:0]    i_terms [NTERMS],
    output lrs_pkg::t_merge_stat                o_stat,
    output logic signed [lrs_pkg::W_W-1:0]      o_z
);

    localparam int ACC_W = lrs_pkg::ACC_W;
    localparam int NPAIR = (NTERMS + 1) / 2;
    localparam int NPAD  = 2 * NPAIR;
    localparam int CNT_W = $clog2(NPAIR + 1);

    logic signed [ACC_W-1:0] r_q [NPAD];
    logic signed [ACC_W-1:0] r_acc;
    logic signed [lrs_pkg::W_W-1:0] r_z;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy;
    logic                    w_step;
    logic                    w_last;

    assign w_step = r_busy && (r_cnt != '0);
    assign w_last = r_busy && (r_cnt == '0);

    // Shift line of terms; the two at the head are added every cycle while the sum runs.
    for (genvar g = 0; g < NPAD; g++) begin : g_q
        logic signed [ACC_W-1:0] w_load_val;
        logic signed [ACC_W-1:0] w_shift_val;
        if (g < NTERMS) begin : g_in
            assign w_load_val = i_terms[g];
        end else begin : g_pad
            assign w_load_val = '0;
        end
        if (g + 2 < NPAD) begin : g_mid
            assign w_shift_val = r_q[g+2];
        end else begin : g_end
            assign w_shift_val = '0;
        end
        always_ff @(posedge i_clk) begin
            if (i_load) begin
                r_q[g] <= w_load_val;
            end else if (w_step) begin
                r_q[g] <= w_shift_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NPAIR);
        end else if (w_step) begin
            r_cnt  <= r_cnt - 1'b1;
        end else if (w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_acc <= '0;
        end else if (w_step) begin
            r_acc <= r_acc + r_q[0] + r_q[1];
        end
        if (w_last) begin
            // Floor from Q24.24 to Q16.16 is a plain bit select.
            r_z <= lrs_pkg::sat_q16(r_acc[ACC_W-1:8]);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.last = w_last;
    assign o_z         = r_z;

endmodule

[sv/lrs_sigmoid.sv]
// Sigmoid lookup: clamps the logit, forms the bin index and reads the constant table.
module lrs_sigmoid #(
    parameter int ENTRIES = lrs_pkg::SIGMOID_ENTRIES
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [lrs_pkg::W_W-1:0]     i_z,
    output logic [lrs_pkg::P_W-1:0]            o_p
);

    localparam int ZC_W  = lrs_pkg::ZC_W;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int SCL_W = ZC_W + $clog2(ENTRIES + 1);

    logic [lrs_pkg::P_W-1:0]  w_tab [ENTRIES];
    logic signed [ZC_W-1:0]   w_zc;
    logic [ZC_W-1:0]          w_u;
    logic [SCL_W-1:0]         w_scaled;
    logic [IDX_W-1:0]         w_idx;
    logic [lrs_pkg::P_W-1:0]  r_p;

    // Each entry holds the sigmoid at the midpoint of its bin over [-8, 8).
    for (genvar k = 0; k < ENTRIES; k++) begin : g_tab
        localparam longint MID = ((longint'(2 * k + 1)) << 19) / ENTRIES - 524288;
        assign w_tab[k] = lrs_pkg::sigmoid_at(MID);
    end

    always_comb begin
        if (i_z < -32'sd524288) begin
            w_zc = {1'b1, {(ZC_W-1){1'b0}}};
        end else if (i_z > 32'sd524287) begin
            w_zc = {1'b0, {(ZC_W-1){1'b1}}};
        end else begin
            w_zc = i_z[ZC_W-1:0];
        end
    end

    // Offset to [0, 2^20) and scale by the table size.
    assign w_u      = {~w_zc[ZC_W-1], w_zc[ZC_W-2:0]};
    assign w_scaled = SCL_W'(w_u) * SCL_W'(ENTRIES);
    assign w_idx    = w_scaled[ZC_W +: IDX_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_tab[w_idx];
        end
    end

    assign o_p = r_p;

endmodule

[sv/logistic_regression_sgd_step_unit.sv]
// Top level of the online logistic regression unit: one SGD step per sample transaction.
// A sample is taken only in idle; it passes the multiply, load, sum and sigmoid table
// states, and its result is registered in the output state. The lane products are summed
// two terms per cycle, and a training sample then runs the error and update states.
// A stalled result only delays the next sample when it is still held at the following result.
// Reset (synchronous, active low) clears weights and bias and sets the learning rate to 655.
module logistic_regression_sgd_step_unit #(
    parameter int SIGMOID_ENTRIES = lrs_pkg::SIGMOID_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration: learning rate, unsigned Q0.16.
    input  logic                                i_cfg_wr_en,
    input  logic [lrs_pkg::LR_W-1:0]            i_cfg_wr_data,
    // Sample channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [lrs_pkg::X_W-1:0]      i_feature_0,
    input  logic signed [lrs_pkg::X_W-1:0]      i_feature_1,
    input  logic signed [lrs_pkg::X_W-1:0]      i_feature_2,
    input  logic signed [lrs_pkg::X_W-1:0]      i_feature_3,
    input  logic signed [lrs_pkg::X_W-1:0]      i_feature_4,
    input  logic signed [lrs_pkg::X_W-1:0]      i_feature_5,
    input  logic signed [lrs_pkg::X_W-1:0]      i_feature_6,
    input  logic signed [lrs_pkg::X_W-1:0]      i_feature_7,
    input  logic signed [lrs_pkg::X_W-1:0]      i_feature_8,
    input  logic                                i_label,
    input  logic                                i_train,
    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [lrs_pkg::P_W-1:0]             o_probability,
    output logic signed [lrs_pkg::W_W-1:0]      o_logit
);

    localparam int FEATURES = lrs_pkg::FEATURES;
    localparam int ACC_W    = lrs_pkg::ACC_W;
    localparam int LRE_W    = lrs_pkg::LRE_W;
    localparam int W_W      = lrs_pkg::W_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;  // waiting for a sample
    localparam logic [3:0] S_MUL  = 4'd1;  // lanes form w*x
    localparam logic [3:0] S_LOAD = 4'd2;  // merge stage takes the products
    localparam logic [3:0] S_SUM  = 4'd3;  // merge stage accumulates
    localparam logic [3:0] S_TAB  = 4'd4;  // sigmoid table read
    localparam logic [3:0] S_OUT  = 4'd5;  // hand the result to the output register
    localparam logic [3:0] S_ERR  = 4'd6;  // lr * (p - label)
    localparam logic [3:0] S_UPM  = 4'd7;  // lanes form the update products, bias updates
    localparam logic [3:0] S_UPA  = 4'd8;  // lanes write the new weights

    logic [3:0]                    r_state;
    logic [3:0]                    n_state;
    logic                          r_label;
    logic                          r_train;
    logic [lrs_pkg::LR_W-1:0]      r_lr;
    logic signed [W_W-1:0]         r_bias;
    logic signed [LRE_W-1:0]       r_lre;
    logic                          r_out_valid;
    logic [lrs_pkg::P_W-1:0]       r_out_p;
    logic signed [W_W-1:0]         r_out_z;

    logic                          w_in_accept;
    logic                          w_out_free;
    logic signed [lrs_pkg::X_W-1:0]  w_x     [FEATURES];
    logic signed [lrs_pkg::PROD_W-1:0] w_prod [FEATURES];
    logic signed [ACC_W-1:0]       w_terms [FEATURES+1];
    lrs_pkg::t_lane_ctrl           w_lctl;
    lrs_pkg::t_merge_stat          w_mst;
    logic signed [W_W-1:0]         w_z;
    logic [lrs_pkg::P_W-1:0]       w_p;
    logic signed [17:0]            w_err;
    logic signed [LRE_W:0]         w_lre_full;
    logic signed [LRE_W:0]         w_brnd;
    logic signed [LRE_W-16:0]      w_bstep;
    logic signed [lrs_pkg::SAT_IN_W-1:0] w_bdiff;

    // The block works on one sample at a time; a new transaction is taken only in idle,
    // while an earlier result may still sit in the output register.
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    // The output register can take a new result when empty or being drained this cycle.
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_x[0] = i_feature_0;
    assign w_x[1] = i_feature_1;
    assign w_x[2] = i_feature_2;
    assign w_x[3] = i_feature_3;
    assign w_x[4] = i_feature_4;
    assign w_x[5] = i_feature_5;
    assign w_x[6] = i_feature_6;
    assign w_x[7] = i_feature_7;
    assign w_x[8] = i_feature_8;

    // Lane control is decoded from the state and, for the feature capture, the input handshake.
    assign w_lctl.load_x  = w_in_accept;
    assign w_lctl.mul_en  = (r_state == S_MUL) || (r_state == S_UPM);
    assign w_lctl.mul_upd = (r_state == S_UPM);
    assign w_lctl.apply   = (r_state == S_UPA);

    // Feature lanes, each with its own weight and multiplier.
    for (genvar g = 0; g < FEATURES; g++) begin : g_lane
        lrs_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_lctl),
            .i_x     (w_x[g]),
            .i_lre   (r_lre),
            .o_prod  (w_prod[g])
        );
        assign w_terms[g+1] = ACC_W'(w_prod[g]);
    end

    // The bias enters the sum at Q24.24, shifted up by 8 bits.
    assign w_terms[0] = {{(ACC_W-W_W-8){r_bias[W_W-1]}}, r_bias, 8'd0};

    lrs_merge #(
        .NTERMS (FEATURES + 1)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_state == S_LOAD),
        .i_terms (w_terms),
        .o_stat  (w_mst),
        .o_z     (w_z)
    );

    lrs_sigmoid #(
        .ENTRIES (SIGMOID_ENTRIES)
    ) u_sigmoid (
        .i_clk (i_clk),
        .i_en  (r_state == S_TAB),
        .i_z   (w_z),
        .o_p   (w_p)
    );

    // Sequencer. The sum state is left on the edge at which the merge stage writes the logit.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_LOAD;
            S_LOAD: n_state = S_SUM;
            S_SUM: begin
                if (w_mst.last) begin
                    n_state = S_TAB;
                end
            end
            S_TAB:  n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = r_train ? S_ERR : S_IDLE;
                end
            end
            S_ERR:  n_state = S_UPM;
            S_UPM:  n_state = S_UPA;
            S_UPA:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_label <= i_label;
            r_train <= i_train;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= lrs_pkg::LR_RESET;
        end else if (i_cfg_wr_en) begin
            r_lr <= i_cfg_wr_data;
        end
    end

    // Error term: p - label in Q0.16, then scaled by the learning rate to Q0.32.
    assign w_err      = $signed({2'b00, w_p}) - $signed({1'b0, r_label, 16'd0});
    assign w_lre_full = w_err * $signed({1'b0, r_lr});

    always_ff @(posedge i_clk) begin
        if (r_state == S_ERR) begin
            r_lre <= LRE_W'(w_lre_full);
        end
    end

    // Bias step: Q0.32 to Q16.16, round to nearest with ties up, then saturate.
    assign w_brnd  = {r_lre[LRE_W-1], r_lre} + {{(LRE_W-15){1'b0}}, 1'b1, 15'd0};
    assign w_bstep = w_brnd[LRE_W:16];
    assign w_bdiff = lrs_pkg::SAT_IN_W'(r_bias) - lrs_pkg::SAT_IN_W'(w_bstep);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= '0;
        end else if (r_state == S_UPM) begin
            r_bias <= lrs_pkg::sat_q16(w_bdiff);
        end
    end

    // Output register: holds one result transaction until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_p <= w_p;
            r_out_z <= w_z;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_probability = r_out_p;
    assign o_logit       = r_out_z;

`include "assert_macros.svh"

    // An accepted sample always starts the lane multiply next.
    `LRS_ASSERT(a_accept_starts, i_clk, i_rst_n, w_in_accept |=> (r_state == S_MUL), "accepted sample did not start the multiply")
    // The merge stage finishes only while the sequencer waits for it.
    `LRS_ASSERT(a_merge_last_in_sum, i_clk, i_rst_n, w_mst.last |-> (r_state == S_SUM), "logit written outside the sum state")
    // The sequencer never waits on a merge stage that is not running.
    `LRS_ASSERT(a_sum_needs_busy, i_clk, i_rst_n, (r_state == S_SUM) |-> w_mst.busy, "sum state with an idle merge stage")
    // The bias only moves in the update state.
    `LRS_ASSERT(a_bias_only_on_update, i_clk, i_rst_n, (r_state != S_UPM) |=> $stable(r_bias), "bias changed outside an update")

endmodule

[tb/tb_logistic_regression_sgd_step_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the logistic regression SGD step unit, with its own predictor.
module tb_logistic_regression_sgd_step_unit;

    localparam int FEATURES        = lrs_pkg::FEATURES;
    localparam int SIGMOID_ENTRIES = lrs_pkg::SIGMOID_ENTRIES;
    localparam int X_W             = lrs_pkg::X_W;
    localparam int W_W             = lrs_pkg::W_W;
    localparam int P_W             = lrs_pkg::P_W;
    localparam int LR_W            = lrs_pkg::LR_W;
    localparam logic [LR_W-1:0] LR_RESET = lrs_pkg::LR_RESET;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 5;
    // The weight write-back trails the result, so this pause leaves the unit truly idle.
    localparam int SETTLE_CYCLES  = 24;
    // Cycles without any transaction before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_SAMPLES  = 275;

    // Idle percentages of the three traffic patterns.
    localparam int IDLE_LIGHT = 14;
    localparam int IDLE_HEAVY = 69;
    localparam int IDLE_NONE  = 0;

    localparam longint Q16_HI = 64'sd2147483647;
    localparam longint Q16_LO = -64'sd2147483648;
    // The sigmoid table spans the logit range [-8, 8) in Q16.16.
    localparam longint ZC_LO  = -64'sd524288;
    localparam longint ZC_HI  = 64'sd524287;
    localparam longint Z_SPAN = 64'sd524288;

    localparam logic [LR_W-1:0] RATE_MIN = '0;
    localparam logic [LR_W-1:0] RATE_ONE = 16'd1;
    localparam logic [LR_W-1:0] RATE_MAX = '1;

    localparam logic [X_W-1:0] X_MAX     = 16'h7FFF;
    localparam logic [X_W-1:0] X_MIN     = 16'h8000;
    localparam logic [X_W-1:0] X_ONE_LSB = 16'h0001;
    localparam logic [X_W-1:0] X_NEG_LSB = 16'hFFFF;

    // How the features of one random sample are drawn.
    typedef enum int {
        STYLE_SMALL,    // within +/-2.0, keeps the logit inside the table
        STYLE_FULL,     // any 16-bit value
        STYLE_TINY,     // a few LSBs around zero
        STYLE_EXTREME,  // limits, zero and one LSB
        STYLE_MIXED     // each feature picks one of the above
    } t_feat_style;

    typedef struct packed {
        logic [FEATURES-1:0][X_W-1:0] x;
        logic                         label;
        logic                         train;
    } t_sample;

    typedef struct packed {
        logic [P_W-1:0] prob;
        logic [W_W-1:0] logit;
    } t_score;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic            cfg_wr_en   = 1'b0;
    logic [LR_W-1:0] cfg_wr_data = '0;

    logic    in_valid   = 1'b0;
    logic    in_stall;
    t_sample cur_sample = '0;

    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [P_W-1:0]        probability;
    logic signed [W_W-1:0] logit;

    // Predictor state: the weights, bias and learning rate as the unit should hold them.
    longint         wt_q [FEATURES];
    longint         bias_q;
    longint         lr_q;
    logic [P_W-1:0] sig_lut [SIGMOID_ENTRIES];
    bit             bin_hit [SIGMOID_ENTRIES];

    t_sample pending_samples [$];
    t_score  expected_scores [$];
    t_score  want;

    // Handshake flags, written at the rising edge and read at the falling edge.
    bit in_taken  = 1'b0;
    bit out_taken = 1'b0;

    int send_idle_pct  = IDLE_LIGHT;
    int recv_stall_pct = IDLE_HEAVY;

    int queued_total = 0;
    int results_seen = 0;
    int n_errors     = 0;
    int idle_cycles  = 0;
    int n_train      = 0;
    int n_sat_logit  = 0;
    int n_rates      = 0;

    always #HALF_PERIOD clk = ~clk;

    logistic_regression_sgd_step_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_feature_0   (cur_sample.x[0]),
        .i_feature_1   (cur_sample.x[1]),
        .i_feature_2   (cur_sample.x[2]),
        .i_feature_3   (cur_sample.x[3]),
        .i_feature_4   (cur_sample.x[4]),
        .i_feature_5   (cur_sample.x[5]),
        .i_feature_6   (cur_sample.x[6]),
        .i_feature_7   (cur_sample.x[7]),
        .i_feature_8   (cur_sample.x[8]),
        .i_label       (cur_sample.label),
        .i_train       (cur_sample.train),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_probability (probability),
        .o_logit       (logit)
    );

    function automatic longint clip32(input longint v);
        if (v > Q16_HI) begin
            return Q16_HI;
        end else if (v < Q16_LO) begin
            return Q16_LO;
        end
        return v;
    endfunction

    // Sigmoid of the midpoint of bin k: exp(-|m|) comes from a series to the fourth power of
    // exp(-|m|/256) in Q31 squared eight times, then one rounded division.
    function automatic logic [P_W-1:0] lut_entry(input int k);
        longint          m;
        longint unsigned a;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned t3;
        longint unsigned t4;
        longint unsigned e;
        longint unsigned d;
        longint unsigned r;
        int              i;
        m  = ((2 * longint'(k) + 1) * Z_SPAN) / SIGMOID_ENTRIES - Z_SPAN;
        a  = (m < 0) ? -m : m;
        t  = a << 7;
        t2 = (t * t) >> 31;
        t3 = (t2 * t) >> 31;
        t4 = (t3 * t) >> 31;
        e  = ((64'd1 << 31) + t2 / 64'd2 + t4 / 64'd24) - (t + t3 / 64'd6);
        for (i = 0; i < 8; i++) begin
            e = (e * e + (64'd1 << 30)) >> 31;
        end
        d = (64'd1 << 31) + e;
        if (m >= 0) begin
            r = ((64'd1 << 47) + d / 64'd2) / d;
        end else begin
            r = ((e << 16) + d / 64'd2) / d;
        end
        return (r > 64'd65535) ? {P_W{1'b1}} : P_W'(r);
    endfunction

    // Scores one accepted sample and, when it trains, takes the SGD step on the
    // predictor's weights and bias exactly as the unit should.
    function automatic t_score score_sample(input t_sample s);
        longint         xv [FEATURES];
        longint         acc;
        longint         z;
        longint         zc;
        longint         err;
        longint         delta;
        int             idx;
        int             i;
        logic [P_W-1:0] p;
        t_score         r;
        acc = bias_q * 256;
        for (i = 0; i < FEATURES; i++) begin
            xv[i] = longint'($signed(s.x[i]));
            acc += wt_q[i] * xv[i];
        end
        // Q24.24 down to Q16.16 with floor, then saturate.
        z   = clip32(acc >>> 8);
        zc  = (z < ZC_LO) ? ZC_LO : ((z > ZC_HI) ? ZC_HI : z);
        idx = int'(((zc + Z_SPAN) * SIGMOID_ENTRIES) >>> 20);
        if (idx >= SIGMOID_ENTRIES) begin
            idx = SIGMOID_ENTRIES - 1;
        end
        p = sig_lut[idx];
        bin_hit[idx] = 1'b1;
        if (z == Q16_HI || z == Q16_LO) begin
            n_sat_logit++;
        end
        if (s.train) begin
            err = longint'(p) - (s.label ? 64'sd65536 : 64'sd0);
            for (i = 0; i < FEATURES; i++) begin
                // Q8.40 step rounded to Q16.16, ties toward plus infinity.
                delta = (lr_q * err * xv[i] + (64'sd1 <<< 23)) >>> 24;
                wt_q[i] = clip32(wt_q[i] - delta);
            end
            bias_q = clip32(bias_q - ((lr_q * err + 64'sd32768) >>> 16));
            n_train++;
        end
        r.prob  = p;
        r.logit = W_W'(z);
        return r;
    endfunction

    function automatic logic [X_W-1:0] pick_feature(input int style);
        int kind;
        kind = style;
        if (style == STYLE_MIXED) begin
            kind = $urandom_range(STYLE_EXTREME, STYLE_SMALL);
        end
        case (kind)
            STYLE_FULL:  return X_W'($urandom);
            STYLE_SMALL: return X_W'($urandom_range(1023, 0) - 512);
            STYLE_TINY:  return X_W'($urandom_range(63, 0) - 32);
            default: begin
                case ($urandom_range(4, 0))
                    0:       return X_MAX;
                    1:       return X_MIN;
                    2:       return '0;
                    3:       return X_NEG_LSB;
                    default: return X_ONE_LSB;
                endcase
            end
        endcase
    endfunction

    // Random sample whose label mostly follows a hidden linear rule, so the
    // weights are pulled somewhere coherent; the rest are noisy labels.
    function automatic t_sample make_sample();
        t_sample s;
        int      pick;
        int      style;
        int      i;
        longint  teach;
        pick = $urandom_range(99, 0);
        if (pick < 40) begin
            style = STYLE_SMALL;
        end else if (pick < 65) begin
            style = STYLE_FULL;
        end else if (pick < 85) begin
            style = STYLE_MIXED;
        end else begin
            style = STYLE_TINY;
        end
        for (i = 0; i < FEATURES; i++) begin
            s.x[i] = pick_feature(style);
        end
        teach = longint'($signed(s.x[0])) - longint'($signed(s.x[2]))
              + longint'($signed(s.x[5]));
        if ($urandom_range(99, 0) < 85) begin
            s.label = (teach > 0);
        end else begin
            s.label = 1'($urandom_range(1, 0));
        end
        s.train = ($urandom_range(99, 0) < 75);
        return s;
    endfunction

    function automatic t_sample uniform_sample(input logic [X_W-1:0] v, input logic lab,
                                               input logic trn);
        t_sample s;
        int      i;
        for (i = 0; i < FEATURES; i++) begin
            s.x[i] = v;
        end
        s.label = lab;
        s.train = trn;
        return s;
    endfunction

    task automatic queue_sample(input t_sample s);
        pending_samples.insert(pending_samples.size(), s);
        queued_total++;
    endtask

    // Blocks until every queued sample has produced its result, then lets the
    // trailing weight update finish.
    task automatic wait_drained();
        while (results_seen != queued_total) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_rate(input logic [LR_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        lr_q = v;
        n_rates++;
    endtask

    // Driver: the sample stays on the port until a rising edge sees it accepted.
    // The result-side stall is drawn fresh each cycle.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        if (!in_valid || in_taken) begin
            if (pending_samples.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                cur_sample <= pending_samples[0];
                pending_samples.delete(0);
                in_valid   <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transaction against the oldest expectation,
    // scores each accepted sample, and watches for a hang.
    always @(posedge clk) begin
        in_taken  = rst_n && in_valid && !in_stall;
        out_taken = rst_n && out_valid && !out_stall;
        if (out_taken) begin
            results_seen++;
            if (expected_scores.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) begin
                    $display("result %0d arrived with no sample waiting for it", results_seen);
                end
            end else begin
                want = expected_scores[0];
                expected_scores.delete(0);
                if (want.prob !== probability || want.logit !== logit) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("result %0d: probability expected %h got %h, logit expected %0d got %0d",
                                 results_seen, want.prob, probability,
                                 $signed(want.logit), logit);
                    end
                end
            end
        end
        if (in_taken) begin
            expected_scores.insert(expected_scores.size(), score_sample(cur_sample));
        end
        if (in_taken || out_taken || !rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [LR_W-1:0] rate_plan [RANDOM_PHASES];
        int              send_plan [3];
        int              stall_plan [3];
        t_sample         s;
        int              k;
        int              ph;
        int              bins_used;
        for (k = 0; k < SIGMOID_ENTRIES; k++) begin
            sig_lut[k] = lut_entry(k);
            bin_hit[k] = 1'b0;
        end
        for (k = 0; k < FEATURES; k++) begin
            wt_q[k] = 0;
        end
        bias_q = 0;
        lr_q   = LR_RESET;

        // Sender idles lightly while the receiver stalls heavily, then the
        // reverse, then full speed on both sides.
        send_plan  = '{IDLE_LIGHT, IDLE_HEAVY, IDLE_NONE};
        stall_plan = '{IDLE_HEAVY, IDLE_LIGHT, IDLE_NONE};
        rate_plan  = '{RATE_MIN, RATE_ONE, RATE_MAX, LR_W'($urandom), LR_RESET,
                       LR_W'($urandom)};
        send_idle_pct  = send_plan[0];
        recv_stall_pct = stall_plan[0];

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset learning rate: zero weights put the first
        // logit on the table midpoint, then feature limits, sign patterns, LSB
        // features, a sample that only predicts, and each feature on its own.
        queue_sample(uniform_sample('0, 1'b0, 1'b0));
        queue_sample(uniform_sample(X_MAX, 1'b1, 1'b1));
        queue_sample(uniform_sample(X_MIN, 1'b0, 1'b1));
        s = uniform_sample(X_MAX, 1'b1, 1'b1);
        for (k = 1; k < FEATURES; k += 2) begin
            s.x[k] = X_MIN;
        end
        queue_sample(s);
        queue_sample(uniform_sample(X_NEG_LSB, 1'b0, 1'b0));
        queue_sample(uniform_sample(X_ONE_LSB, 1'b1, 1'b1));
        for (k = 0; k < FEATURES; k++) begin
            s = uniform_sample('0, 1'(k % 2), 1'b1);
            s.x[k] = X_MAX;
            queue_sample(s);
        end
        wait_drained();

        // Largest step size: a few training samples at the limits push the sum
        // far past the 32-bit range, so the logit saturates high and then low.
        set_rate(RATE_MAX);
        repeat (3) queue_sample(uniform_sample(X_MAX, 1'b1, 1'b1));
        queue_sample(uniform_sample(X_MIN, 1'b1, 1'b1));
        queue_sample(uniform_sample(X_MAX, 1'b0, 1'b0));
        queue_sample(uniform_sample(X_MIN, 1'b0, 1'b0));
        queue_sample(uniform_sample(X_ONE_LSB, 1'b0, 1'b0));
        queue_sample(uniform_sample(X_MIN, 1'b0, 1'b1));
        wait_drained();

        // Random phases, each at its own learning rate, two per traffic pattern.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_rate(rate_plan[ph]);
            send_idle_pct  = send_plan[ph / 2];
            recv_stall_pct = stall_plan[ph / 2];
            for (k = 0; k < PHASE_SAMPLES; k++) begin
                queue_sample(make_sample());
            end
            wait_drained();
        end

        if (expected_scores.size() != 0) begin
            n_errors += expected_scores.size();
            $display("%0d expected results never arrived", expected_scores.size());
        end
        bins_used = 0;
        for (k = 0; k < SIGMOID_ENTRIES; k++) begin
            bins_used += bin_hit[k];
        end
        $display("Checked %0d results from %0d samples (%0d training) at %0d learning rates.",
                 results_seen, queued_total, n_train, n_rates);
        $display("Saturated logits: %0d; sigmoid bins reached: %0d of %0d.",
                 n_sat_logit, bins_used, SIGMOID_ENTRIES);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
